// ===== rtl/core/tmp_pkg.sv =====
// Shared constants, command and status types and a modular add helper for the tribonacci core.
package tmp_pkg;

   localparam int ModW    = 31;
   localparam int IdxW    = 63;
   localparam int RamAw   = 6;
   localparam int RamDepth = 64;
   localparam logic [ModW-1:0] MODULUS_RESET = 31'd1000000009;

   // Controller to datapath commands.
   typedef struct packed {
      logic       accept;
      logic       take_short;
      logic       init_wr;
      logic       init_base;
      logic       rd;
      logic       fin_rd;
      logic       sq;
      logic [1:0] i;
      logic [1:0] j;
      logic [1:0] k;
      logic       mul_start;
      logic       acc_add;
      logic       acc_first;
      logic       wr_entry;
      logic       flip;
      logic       shift_p;
      logic       fin_dbl;
      logic       fin_add;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic short_case;
      logic p_zero;
      logic p_lsb;
      logic mul_done;
   } status_type;

   // Modular add of two residues already below the modulus.
   function automatic logic [ModW-1:0] mod_add(input logic [ModW-1:0] x,
                                               input logic [ModW-1:0] y,
                                               input logic [ModW-1:0] m);
      logic [ModW:0] s;
      logic [ModW:0] d;
      s = {1'b0, x} + {1'b0, y};
      d = s - {1'b0, m};
      if (s >= {1'b0, m}) begin
         return d[ModW-1:0];
      end
      return s[ModW-1:0];
   endfunction

endpackage

// ===== rtl/core/tribonacci_matrix_power_mod.sv =====
// Top level: tribonacci term modulo a configurable modulus by matrix powering.
//
//   Channel   Ports                                  Beat taken when
//   request   start, busy, req_term_index            start && !busy
//   response  rsp_valid, rsp_term_value              rsp_valid (one cycle)
//   csr       csr_valid, csr_ready, csr_data         csr_valid && csr_ready
//
// Indices 0 to 2, and any index when the modulus is below two, skip the matrix products.
// Otherwise each 3x3 matrix product takes nine entries of three multiplies each on the
// bit-serial modular multiplier, after the identity and base matrices are initialised;
// up to two products per exponent bit.
// Reset is synchronous and returns the modulus to 1000000009. The receiver cannot stall.
module tribonacci_matrix_power_mod
   import tmp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic [IdxW-1:0] req_term_index,
   output logic            rsp_valid,
   output logic [ModW-1:0] rsp_term_value,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [ModW-1:0] csr_data
);

   logic [ModW-1:0] modulus_ff;
   cmd_type         cmd;
   status_type      status;

   // Modulus register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff <= MODULUS_RESET;
      end else if (csr_valid && csr_ready) begin
         modulus_ff <= csr_data;
      end
   end

   tmp_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .status   (status),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   tmp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .term_index(req_term_index),
      .modulus   (modulus_ff),
      .status    (status),
      .result    (rsp_term_value)
   );

`ifndef SYNTHESIS
   // A result beat lasts exactly one cycle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for more than one cycle");

   // A result is always reduced below a valid modulus.
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (modulus_ff >= 31'd2)) |-> (rsp_term_value < modulus_ff))
      else $error("response not reduced modulo the modulus");

   // An accepted request makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");
`endif

endmodule

// ===== rtl/core/tmp_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module tmp_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write port and registered reads.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ===== rtl/core/tmp_mulmod.sv =====
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
module tmp_mulmod
   import tmp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [ModW-1:0] a_in,
   input  logic [ModW-1:0] b_in,
   input  logic [ModW-1:0] modulus,
   output logic [ModW-1:0] product,
   output logic            done
);

   logic [ModW-1:0] a_ff, a_in_n;
   logic [ModW-1:0] b_ff, b_in_n;
   logic [ModW-1:0] r_ff, r_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [ModW-1:0] dbl;
   logic [ModW-1:0] addend;

   // Double the partial residue, then add the multiplicand when the bit is set.
   always_comb begin
      a_in_n  = a_ff;
      b_in_n  = b_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dbl     = mod_add(r_ff, r_ff, modulus);
      addend  = b_ff[cnt_ff] ? a_ff : '0;
      if (start) begin
         a_in_n  = a_in;
         b_in_n  = b_in;
         r_in    = '0;
         cnt_in  = 5'(ModW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in = mod_add(dbl, addend, modulus);
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in_n;
      b_ff   <= b_in_n;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product = r_ff;
   assign done    = done_ff;

endmodule

// ===== rtl/core/tmp_datapath.sv =====
// Datapath: matrix store, shared modular multiplier, exponent and result registers.
module tmp_datapath
   import tmp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   input  logic [IdxW-1:0] term_index,
   input  logic [ModW-1:0] modulus,
   output status_type      status,
   output logic [ModW-1:0] result
);

   logic [IdxW-1:0] p_ff, p_in;
   logic            short_ff, short_in;
   logic            short_val_ff, short_val_in;
   logic            acc_slot_ff, acc_slot_in;
   logic            base_slot_ff, base_slot_in;
   logic [ModW-1:0] sum_ff, sum_in;
   logic [ModW-1:0] res_ff, res_in;

   logic [RamAw-1:0] addr_x, addr_y, wr_addr;
   logic [ModW-1:0]  wr_data, dx, dy, prod;
   logic             wr_en, mul_done, init_one;
   logic [1:0]       x_slot, acc_s, base_s;

   assign acc_s  = {1'b0, acc_slot_ff};
   assign base_s = {1'b1, base_slot_ff};

   // Read and write addresses: slot, row, column.
   always_comb begin
      x_slot = cmd.sq ? base_s : acc_s;
      if (cmd.fin_rd) begin
         addr_x = {acc_s, 2'd0, 2'd0};
         addr_y = {acc_s, 2'd0, 2'd1};
      end else begin
         addr_x = {x_slot, cmd.i, cmd.k};
         addr_y = {base_s, cmd.k, cmd.j};
      end
      if (cmd.init_base) begin
         init_one = (cmd.i == 2'd0) || ((cmd.i == 2'd1) && (cmd.j == 2'd0)) ||
                    ((cmd.i == 2'd2) && (cmd.j == 2'd1));
      end else begin
         init_one = (cmd.i == cmd.j);
      end
      if (cmd.init_wr) begin
         wr_addr = {(cmd.init_base ? base_s : acc_s), cmd.i, cmd.j};
         wr_data = {{(ModW-1){1'b0}}, init_one};
      end else begin
         wr_addr = cmd.sq ? {1'b1, ~base_slot_ff, cmd.i, cmd.j}
                          : {1'b0, ~acc_slot_ff, cmd.i, cmd.j};
         wr_data = sum_ff;
      end
      wr_en = cmd.init_wr | cmd.wr_entry;
   end

   tmp_ram #(
      .WIDTH(ModW),
      .DEPTH(RamDepth)
   ) u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (cmd.rd | cmd.fin_rd),
      .rd_addr_a(addr_x),
      .rd_addr_b(addr_y),
      .rd_data_a(dx),
      .rd_data_b(dy)
   );

   tmp_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .a_in   (dx),
      .b_in   (dy),
      .modulus(modulus),
      .product(prod),
      .done   (mul_done)
   );

   // Register updates driven by the controller's commands.
   always_comb begin
      p_in         = p_ff;
      short_in     = short_ff;
      short_val_in = short_val_ff;
      acc_slot_in  = acc_slot_ff;
      base_slot_in = base_slot_ff;
      sum_in       = sum_ff;
      res_in       = res_ff;
      if (cmd.accept) begin
         p_in         = term_index - IdxW'(3);
         short_in     = (modulus < ModW'(2)) || (term_index <= IdxW'(2));
         short_val_in = (modulus >= ModW'(2)) && (term_index == IdxW'(2));
         acc_slot_in  = 1'b0;
         base_slot_in = 1'b0;
      end
      if (cmd.take_short) begin
         res_in = {{(ModW-1){1'b0}}, short_val_ff};
      end
      if (cmd.acc_add) begin
         sum_in = cmd.acc_first ? prod : mod_add(sum_ff, prod, modulus);
      end
      if (cmd.flip) begin
         if (cmd.sq) begin
            base_slot_in = ~base_slot_ff;
         end else begin
            acc_slot_in = ~acc_slot_ff;
         end
      end
      if (cmd.shift_p) begin
         p_in = {1'b0, p_ff[IdxW-1:1]};
      end
      if (cmd.fin_dbl) begin
         res_in = mod_add(dx, dx, modulus);
      end
      if (cmd.fin_add) begin
         res_in = mod_add(res_ff, dy, modulus);
      end
   end

   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      short_ff     <= short_in;
      short_val_ff <= short_val_in;
      sum_ff       <= sum_in;
      res_ff       <= res_in;
      if (reset) begin
         acc_slot_ff  <= 1'b0;
         base_slot_ff <= 1'b0;
      end else begin
         acc_slot_ff  <= acc_slot_in;
         base_slot_ff <= base_slot_in;
      end
   end

   assign status.short_case = short_ff;
   assign status.p_zero     = (p_ff == '0);
   assign status.p_lsb      = p_ff[0];
   assign status.mul_done   = mul_done;
   assign result            = res_ff;

endmodule

// ===== rtl/core/tmp_ctrl.sv =====
// Controller state machine sequencing init, matrix products and the final sum.
module tmp_ctrl
   import tmp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   typedef enum logic [12:0] {
      S_IDLE    = 13'h0001,
      S_DECIDE  = 13'h0002,
      S_INIT    = 13'h0004,
      S_CHECK   = 13'h0008,
      S_RD      = 13'h0010,
      S_MST     = 13'h0020,
      S_MWAIT   = 13'h0040,
      S_ADD     = 13'h0080,
      S_WR      = 13'h0100,
      S_FIN_RD  = 13'h0200,
      S_FIN_DBL = 13'h0400,
      S_FIN_ADD = 13'h0800,
      S_RESP    = 13'h1000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic       sq_ff, sq_in;
   logic       ib_ff, ib_in;
   logic       last_ij;

   assign last_ij = (i_ff == 2'd2) && (j_ff == 2'd2);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      sq_in    = sq_ff;
      ib_in    = ib_ff;
      cmd      = '0;
      cmd.i    = i_ff;
      cmd.j    = j_ff;
      cmd.k    = k_ff;
      cmd.sq   = sq_ff;
      cmd.init_base = ib_ff;
      // Row-major walk over the nine matrix entries.
      if (j_ff == 2'd2) begin
         j_in = 2'd0;
         i_in = i_ff + 2'd1;
      end else begin
         j_in = j_ff + 2'd1;
      end
      if (!((state_ff == S_INIT) || (state_ff == S_WR))) begin
         i_in = i_ff;
         j_in = j_ff;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (status.short_case) begin
               cmd.take_short = 1'b1;
               state_in       = S_RESP;
            end else begin
               i_in     = 2'd0;
               j_in     = 2'd0;
               ib_in    = 1'b0;
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init_wr = 1'b1;
            if (last_ij) begin
               i_in = 2'd0;
               j_in = 2'd0;
               if (ib_ff) begin
                  state_in = S_CHECK;
               end else begin
                  ib_in = 1'b1;
               end
            end
         end
         S_CHECK: begin
            if (status.p_zero) begin
               state_in = S_FIN_RD;
            end else begin
               sq_in    = ~status.p_lsb;
               i_in     = 2'd0;
               j_in     = 2'd0;
               k_in     = 2'd0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_MST;
         end
         S_MST: begin
            cmd.mul_start = 1'b1;
            state_in      = S_MWAIT;
         end
         S_MWAIT: begin
            if (status.mul_done) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            cmd.acc_add   = 1'b1;
            cmd.acc_first = (k_ff == 2'd0);
            if (k_ff == 2'd2) begin
               k_in     = 2'd0;
               state_in = S_WR;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = S_RD;
            end
         end
         S_WR: begin
            cmd.wr_entry = 1'b1;
            state_in     = S_RD;
            if (last_ij) begin
               cmd.flip = 1'b1;
               i_in     = 2'd0;
               j_in     = 2'd0;
               if (sq_ff) begin
                  cmd.shift_p = 1'b1;
                  state_in    = S_CHECK;
               end else begin
                  sq_in = 1'b1;
               end
            end
         end
         S_FIN_RD: begin
            cmd.fin_rd = 1'b1;
            state_in   = S_FIN_DBL;
         end
         S_FIN_DBL: begin
            cmd.fin_dbl = 1'b1;
            state_in    = S_FIN_ADD;
         end
         S_FIN_ADD: begin
            cmd.fin_add = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff  <= i_in;
      j_ff  <= j_in;
      k_ff  <= k_in;
      sq_ff <= sq_in;
      ib_ff <= ib_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the tribonacci matrix-power modulo block.
`timescale 1ns / 1ps

module tb;
   import tmp_pkg::*;

   typedef longint unsigned mat_type [3][3];

   localparam int StallLimit = 400000;

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   logic [IdxW-1:0] req_term_index;
   logic            rsp_valid;
   logic [ModW-1:0] rsp_term_value;
   logic            csr_valid;
   logic            csr_ready;
   logic [ModW-1:0] csr_data;

   logic [IdxW-1:0] pending_index[$];
   logic [ModW-1:0] expected_value[$];
   logic [ModW-1:0] model_modulus;
   int              error_count;
   int              stall_cycles = 0;
   bit              idle_enable;

   tribonacci_matrix_power_mod uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_term_index(req_term_index),
      .rsp_valid(rsp_valid),
      .rsp_term_value(rsp_term_value),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   // Free-running clock, 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Product of two 3x3 matrices, each entry reduced modulo m.
   function automatic mat_type mat_product(input mat_type x, input mat_type y,
                                           input longint unsigned m);
      mat_type r;
      longint unsigned sum;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            sum = 0;
            for (int k = 0; k < 3; k++) begin
               sum += (x[i][k] * y[k][j]) % m;
            end
            r[i][j] = sum % m;
         end
      end
      return r;
   endfunction

   // Tribonacci term n modulo m, by powering the companion matrix.
   function automatic logic [ModW-1:0] tribonacci_term(input logic [IdxW-1:0] n,
                                                       input logic [ModW-1:0] mod);
      mat_type acc;
      mat_type base;
      longint unsigned m;
      longint unsigned p;
      m = mod;
      if (m < 2 || n <= 1) begin
         return '0;
      end
      if (n == 2) begin
         return ModW'(1);
      end
      acc = '{'{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1}};
      base = '{'{1, 1, 1}, '{1, 0, 0}, '{0, 1, 0}};
      p = n - 3;
      while (p > 0) begin
         if (p[0]) begin
            acc = mat_product(acc, base, m);
         end
         base = mat_product(base, base, m);
         p >>= 1;
      end
      return ModW'((2 * acc[0][0] + acc[0][1]) % m);
   endfunction

   task automatic report(input string what, input longint unsigned got,
                         input longint unsigned want);
      $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Request driver: presents the oldest pending index, idling at random.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (pending_index.size() > 0 && !(idle_enable && $urandom_range(99) < 38)) begin
         start          <= 1'b1;
         req_term_index <= pending_index[0];
      end else begin
         start <= 1'b0;
      end
   end

   // Monitor: predicts accepted beats, checks responses, tracks the modulus, stops on a stall.
   always @(posedge clock) begin
      if (!reset) begin
         if ((csr_valid && csr_ready) || (start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
         if (csr_valid && csr_ready) begin
            model_modulus = csr_data;
         end
         if (start && !busy) begin
            expected_value.push_back(tribonacci_term(req_term_index, model_modulus));
            void'(pending_index.pop_front());
         end
         if (rsp_valid) begin
            if (expected_value.size() == 0) begin
               report("unexpected beat, term_value", rsp_term_value, 0);
            end else begin
               if (rsp_term_value !== expected_value[0]) begin
                  report("term_value", rsp_term_value, expected_value[0]);
               end
               void'(expected_value.pop_front());
            end
         end
         if (stall_cycles >= StallLimit) begin
            $display("tribonacci_matrix_power_mod: mismatch");
            $finish;
         end
      end
   end

   // Waits until every queued item is taken and every response has arrived.
   task automatic drain();
      wait (pending_index.size() == 0 && expected_value.size() == 0);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [ModW-1:0] value);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly small indices so the run stays short; a rare full-width one.
   function automatic logic [IdxW-1:0] random_index();
      logic [IdxW-1:0] n;
      if ($urandom_range(49) == 0) begin
         n = IdxW'({$urandom, $urandom});
         if (n == 0) n = IdxW'(1);
      end else begin
         n = IdxW'($urandom_range(200, 1));
      end
      return n;
   endfunction

   task automatic random_items(input int count);
      for (int i = 0; i < count; i++) begin
         pending_index.push_back(random_index());
      end
   endtask

   initial begin
      reset          = 1'b1;
      csr_valid      = 1'b0;
      csr_data       = '0;
      model_modulus  = MODULUS_RESET;
      error_count    = 0;
      idle_enable    = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: short indices, small powers, widths' extremes, at reset modulus.
      pending_index.push_back(IdxW'(1));
      pending_index.push_back(IdxW'(2));
      pending_index.push_back(IdxW'(3));
      pending_index.push_back(IdxW'(4));
      pending_index.push_back(IdxW'(5));
      pending_index.push_back(IdxW'(6));
      pending_index.push_back(IdxW'(1) << 10);
      pending_index.push_back({IdxW{1'b1}});
      pending_index.push_back(63'd1 << 62);
      drain();

      // Modulus of zero and of one: every term reads zero.
      write_modulus(ModW'(0));
      pending_index.push_back(IdxW'(1));
      pending_index.push_back(IdxW'(2));
      pending_index.push_back(IdxW'(7));
      write_modulus(ModW'(1));
      pending_index.push_back(IdxW'(2));
      pending_index.push_back(IdxW'(9));

      // Smallest and largest meaningful moduli.
      write_modulus(ModW'(2));
      pending_index.push_back(IdxW'(2));
      pending_index.push_back(IdxW'(20));
      random_items(20);
      write_modulus(31'h7FFF_FFFF);
      pending_index.push_back(IdxW'(2));
      pending_index.push_back(IdxW'(100));
      random_items(30);

      // A stretch with no idling on the request side.
      idle_enable = 1'b0;
      write_modulus(ModW'(3));
      random_items(30);
      drain();
      idle_enable = 1'b1;

      write_modulus(ModW'($urandom_range(31'h7FFF_FFFF, 2)));
      random_items(35);
      write_modulus(MODULUS_RESET);
      random_items(30);
      drain();

      if (error_count == 0) begin
         $display("tribonacci_matrix_power_mod: match");
      end else begin
         $display("tribonacci_matrix_power_mod: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/tmp_pkg.sv
rtl/core/tmp_ram.sv
rtl/core/tmp_mulmod.sv
rtl/core/tmp_datapath.sv
rtl/core/tmp_ctrl.sv
rtl/core/tribonacci_matrix_power_mod.sv
verif/tb.sv
